### hw/rtl/assert_macros.svh
// assertion helpers, all checks run on clk and are off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### hw/rtl/tacs_pkg.sv
package tacs_pkg;

  localparam int SAMPLE_W = 10;
  localparam int PIX_W    = 12;
  localparam int PRESS_W  = 4;
  // widest per-axis sum over the supported samples per axis (up to 64)
  localparam int SUM_W    = 16;
  // shared divider: dividend holds scale * offset, divisor holds a span
  localparam int DVD_W    = PIX_W + SAMPLE_W;
  localparam int DVS_W    = SAMPLE_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PIX_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_PRESSES = 2'd0,
    REG_SCREEN_W    = 2'd1,
    REG_SCREEN_H    = 2'd2
  } cfg_reg_t;

  localparam logic [PRESS_W-1:0] CAL_PRESSES_RST = 4'd4;
  localparam logic [PIX_W-1:0]   SCREEN_W_RST    = 12'd320;
  localparam logic [PIX_W-1:0]   SCREEN_H_RST    = 12'd240;

  // one finished press handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] x_sum;
    logic [SUM_W-1:0] y_sum;
    logic             calib;
    logic             seed;
  } job_t;

  // calibration restart request from the config port
  typedef struct packed {
    logic               we;
    logic [PRESS_W-1:0] presses;
  } cal_wr_t;

endpackage

### hw/rtl/touch_average_calibrate_scale.sv
// input: one sample a cycle while the two-entry press queue has a free slot
// back end per press: a calibration press only averages and updates the bounds, a scaling
// press also runs up to two divides on the shared restoring divider at one quotient bit a cycle
// the back end works on one press at a time, and a full queue stalls the input
// reset (rst_n low, synchronous): queue and output empty, bounds zero, 4 presses, 320 x 240
module touch_average_calibrate_scale #(
  parameter int SAMPLES_PER_AXIS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tacs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tacs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // adc_sample[9:0], zeros
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [23:0]                        out_tdata,  // x_pixel[11:0], y_pixel[23:12]
  output logic                               out_tuser   // calibrating
);
  import tacs_pkg::*;

  logic [PIX_W-1:0] scr_w_r, scr_w_nxt, scr_h_r, scr_h_nxt;
  cal_wr_t          cal_wr;
  logic             in_acc, q_push, q_ready, q_pop, q_valid;
  job_t             push_job, pop_job;
  logic [PIX_W-1:0] ox, oy;
  logic             oc;

  assign cal_wr.we      = cfg_we && (cfg_index == REG_CAL_PRESSES);
  assign cal_wr.presses = cfg_wdata[PRESS_W-1:0];

  always_comb begin
    scr_w_nxt = scr_w_r;
    scr_h_nxt = scr_h_r;
    if (cfg_we && cfg_index == REG_SCREEN_W) scr_w_nxt = cfg_wdata;
    if (cfg_we && cfg_index == REG_SCREEN_H) scr_h_nxt = cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCREEN_W_RST;
      scr_h_r <= SCREEN_H_RST;
    end else begin
      scr_w_r <= scr_w_nxt;
      scr_h_r <= scr_h_nxt;
    end
  end

  assign in_tready = q_ready;
  assign in_acc    = in_tvalid && q_ready;

  tacs_front #(
    .SAMPLES_PER_AXIS(SAMPLES_PER_AXIS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cal_wr    (cal_wr),
    .smp_valid (in_acc),
    .smp       (in_tdata[SAMPLE_W-1:0]),
    .push      (q_push),
    .job       (push_job)
  );

  tacs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_job    (pop_job)
  );

  tacs_back #(
    .SAMPLES_PER_AXIS(SAMPLES_PER_AXIS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .screen_w  (scr_w_r),
    .screen_h  (scr_h_r),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (ox),
    .out_y     (oy),
    .out_calib (oc)
  );

  assign out_tdata = {oy, ox};
  assign out_tuser = oc;

  `include "assert_macros.svh"

  `ASSERT_AT(a_push_room, q_push |-> q_ready, "press pushed into a full queue")
  `ASSERT_AT(a_push_seen, q_push |=> q_valid, "pushed press not visible to back end")
  `ASSERT_NEVER(a_pop_empty, q_pop && !q_valid, "back end popped an empty queue")
  `ASSERT_AT(a_cal_zero, (out_tvalid && out_tuser) |-> (out_tdata == '0),
             "calibration word carries nonzero pixels")

endmodule

### hw/rtl/tacs_front.sv
module tacs_front #(
  parameter int SAMPLES_PER_AXIS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tacs_pkg::cal_wr_t              cal_wr,
  input  logic                           smp_valid,
  input  logic [tacs_pkg::SAMPLE_W-1:0]  smp,
  output logic                           push,
  output tacs_pkg::job_t                 job
);
  import tacs_pkg::*;

  localparam int FSUM_W = SAMPLE_W + $clog2(SAMPLES_PER_AXIS);
  localparam int IDX_W  = $clog2(2 * SAMPLES_PER_AXIS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(2 * SAMPLES_PER_AXIS - 1);
  localparam logic [IDX_W-1:0] Y_IDX    = IDX_W'(SAMPLES_PER_AXIS);

  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [FSUM_W-1:0]  x_sum_r, x_sum_nxt, y_sum_r, y_sum_nxt;
  logic [FSUM_W-1:0]  x_add, y_add;
  logic [PRESS_W-1:0] left_r, left_nxt;
  logic               first_r, first_nxt;
  logic               is_y, is_last;

  assign is_y    = (idx_r >= Y_IDX);
  assign is_last = (idx_r == LAST_IDX);
  assign x_add   = x_sum_r + FSUM_W'(smp);
  assign y_add   = y_sum_r + FSUM_W'(smp);

  assign push        = smp_valid && is_last;
  assign job.x_sum   = SUM_W'(x_sum_r);
  assign job.y_sum   = SUM_W'(y_add);
  assign job.calib   = (left_r != '0);
  assign job.seed    = first_r;

  always_comb begin
    idx_nxt   = idx_r;
    x_sum_nxt = x_sum_r;
    y_sum_nxt = y_sum_r;
    left_nxt  = left_r;
    first_nxt = first_r;
    if (smp_valid) begin
      if (is_last) begin
        idx_nxt   = '0;
        x_sum_nxt = '0;
        y_sum_nxt = '0;
        // calibration presses count down and clear the seed flag
        if (left_r != '0) begin
          left_nxt  = left_r - PRESS_W'(1);
          first_nxt = 1'b0;
        end
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
        if (is_y) begin
          y_sum_nxt = y_add;
        end else begin
          x_sum_nxt = x_add;
        end
      end
    end
    if (cal_wr.we) begin
      left_nxt  = cal_wr.presses;
      first_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      x_sum_r <= '0;
      y_sum_r <= '0;
      left_r  <= CAL_PRESSES_RST;
      first_r <= 1'b1;
    end else begin
      idx_r   <= idx_nxt;
      x_sum_r <= x_sum_nxt;
      y_sum_r <= y_sum_nxt;
      left_r  <= left_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

### hw/rtl/tacs_queue.sv
module tacs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tacs_pkg::job_t push_job,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output tacs_pkg::job_t pop_job
);
  import tacs_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_job    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/tacs_back.sv
module tacs_back #(
  parameter int SAMPLES_PER_AXIS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tacs_pkg::PIX_W-1:0]  screen_w,
  input  logic [tacs_pkg::PIX_W-1:0]  screen_h,
  input  logic                        q_valid,
  input  tacs_pkg::job_t              q_job,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tacs_pkg::PIX_W-1:0]  out_x,
  output logic [tacs_pkg::PIX_W-1:0]  out_y,
  output logic                        out_calib
);
  import tacs_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  // floor(sum / SAMPLES_PER_AXIS) as (sum * ceil(2^AVG_SH / SAMPLES_PER_AXIS)) >> AVG_SH,
  // exact for every sum below 2^SUM_W
  localparam int AVG_SH = SUM_W + $clog2(SAMPLES_PER_AXIS);
  localparam int AVG_MUL = ((1 << AVG_SH) + SAMPLES_PER_AXIS - 1) / SAMPLES_PER_AXIS;
  localparam logic [SUM_W:0] AVG_MUL_C = (SUM_W + 1)'(AVG_MUL);
  localparam int PROD_W = 2 * SUM_W + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIVX  = 9'b000000010,
    S_DIVY  = 9'b000000100,
    S_BOUND = 9'b000001000,
    S_MULX  = 9'b000010000,
    S_DIVPX = 9'b000100000,
    S_MULY  = 9'b001000000,
    S_DIVPY = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [DVD_W-1:0]    dvd_r, dvd_nxt;
  logic [DVS_W-1:0]    dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    ysum_r, ysum_nxt;
  logic                calib_r, calib_nxt, seed_r, seed_nxt;
  logic [SAMPLE_W-1:0] xa_r, xa_nxt, ya_r, ya_nxt;
  logic [SAMPLE_W-1:0] xlo_r, xlo_nxt, xhi_r, xhi_nxt, ylo_r, ylo_nxt, yhi_r, yhi_nxt;
  logic [PIX_W-1:0]    xp_r, xp_nxt, yp_r, yp_nxt;
  logic                ov_r, ov_nxt;
  logic [PIX_W-1:0]    ox_r, ox_nxt, oy_r, oy_nxt;
  logic                oc_r, oc_nxt;

  // one restoring divide step per cycle
  logic [DVS_W:0]   rem_sh, rem_dif;
  logic             ge, div_last;
  logic [DVS_W-1:0] rem_step;
  logic [DVD_W-1:0] quo_step;

  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign ge       = (rem_sh >= {1'b0, dvs_r});
  assign rem_dif  = rem_sh - {1'b0, dvs_r};
  assign rem_step = ge ? rem_dif[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  assign quo_step = {dvd_r[DVD_W-2:0], ge};
  assign div_last = (cnt_r == CNT_W'(1));

  // per-axis average of the sum held in dvd_r
  logic [PROD_W-1:0]   avg_prod;
  logic [SAMPLE_W-1:0] avg_q;

  assign avg_prod = PROD_W'(dvd_r[SUM_W-1:0]) * PROD_W'(AVG_MUL_C);
  assign avg_q    = avg_prod[AVG_SH +: SAMPLE_W];

  // clamp, offset and product for whichever axis is up
  logic [SAMPLE_W-1:0] m_v, m_lo, m_hi, m_cl, m_off, m_span;
  logic [PIX_W-1:0]    m_scale;
  logic [DVD_W-1:0]    m_prod;
  logic                m_flat;

  always_comb begin
    if (state_r == S_MULY) begin
      m_v = ya_r; m_lo = ylo_r; m_hi = yhi_r; m_scale = screen_h;
    end else begin
      m_v = xa_r; m_lo = xlo_r; m_hi = xhi_r; m_scale = screen_w;
    end
    if (m_v < m_lo) begin
      m_cl = m_lo;
    end else if (m_v > m_hi) begin
      m_cl = m_hi;
    end else begin
      m_cl = m_v;
    end
    m_off  = m_cl - m_lo;
    m_span = m_hi - m_lo;
    m_flat = (m_hi <= m_lo);
    m_prod = DVD_W'(m_scale) * DVD_W'(m_off);
  end

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_calib = oc_r;

  always_comb begin
    state_nxt = state_r;
    dvd_nxt   = dvd_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    ysum_nxt  = ysum_r;
    calib_nxt = calib_r;
    seed_nxt  = seed_r;
    xa_nxt    = xa_r;
    ya_nxt    = ya_r;
    xlo_nxt   = xlo_r;
    xhi_nxt   = xhi_r;
    ylo_nxt   = ylo_r;
    yhi_nxt   = yhi_r;
    xp_nxt    = xp_r;
    yp_nxt    = yp_r;
    ov_nxt    = ov_r && !out_ready;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    oc_nxt    = oc_r;
    if (state_r == S_DIVPX || state_r == S_DIVPY) begin
      dvd_nxt = quo_step;
      rem_nxt = rem_step;
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          dvd_nxt   = DVD_W'(q_job.x_sum);
          ysum_nxt  = q_job.y_sum;
          calib_nxt = q_job.calib;
          seed_nxt  = q_job.seed;
          state_nxt = S_DIVX;
        end
      end
      S_DIVX: begin
        xa_nxt    = avg_q;
        dvd_nxt   = DVD_W'(ysum_r);
        state_nxt = S_DIVY;
      end
      S_DIVY: begin
        ya_nxt    = avg_q;
        state_nxt = calib_r ? S_BOUND : S_MULX;
      end
      S_BOUND: begin
        if (seed_r) begin
          xlo_nxt = xa_r; xhi_nxt = xa_r; ylo_nxt = ya_r; yhi_nxt = ya_r;
        end else begin
          if (xa_r < xlo_r) xlo_nxt = xa_r;
          if (xa_r > xhi_r) xhi_nxt = xa_r;
          if (ya_r < ylo_r) ylo_nxt = ya_r;
          if (ya_r > yhi_r) yhi_nxt = ya_r;
        end
        xp_nxt    = '0;
        yp_nxt    = '0;
        state_nxt = S_OUT;
      end
      S_MULX: begin
        if (m_flat) begin
          xp_nxt    = '0;
          state_nxt = S_MULY;
        end else begin
          dvd_nxt   = m_prod;
          dvs_nxt   = m_span;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(DVD_W);
          state_nxt = S_DIVPX;
        end
      end
      S_DIVPX: begin
        if (div_last) begin
          xp_nxt    = quo_step[PIX_W-1:0];
          state_nxt = S_MULY;
        end
      end
      S_MULY: begin
        if (m_flat) begin
          yp_nxt    = '0;
          state_nxt = S_OUT;
        end else begin
          dvd_nxt   = m_prod;
          dvs_nxt   = m_span;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(DVD_W);
          state_nxt = S_DIVPY;
        end
      end
      S_DIVPY: begin
        if (div_last) begin
          yp_nxt    = quo_step[PIX_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hand over once the output register is free
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          ox_nxt    = xp_r;
          oy_nxt    = yp_r;
          oc_nxt    = calib_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      xlo_r   <= '0;
      xhi_r   <= '0;
      ylo_r   <= '0;
      yhi_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      xlo_r   <= xlo_nxt;
      xhi_r   <= xhi_nxt;
      ylo_r   <= ylo_nxt;
      yhi_r   <= yhi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r   <= dvd_nxt;
    dvs_r   <= dvs_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    ysum_r  <= ysum_nxt;
    calib_r <= calib_nxt;
    seed_r  <= seed_nxt;
    xa_r    <= xa_nxt;
    ya_r    <= ya_nxt;
    xp_r    <= xp_nxt;
    yp_r    <= yp_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oc_r    <= oc_nxt;
  end

endmodule

### tb/tb_touch_average_calibrate_scale.sv
module tb_touch_average_calibrate_scale;
  timeunit 1ns;
  timeprecision 1ps;

  import tacs_pkg::*;

  localparam int PER_AXIS      = 8;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int N_STEPS       = 24;
  localparam int N_PHASES      = 5;
  localparam int HOLD_PRESSES  = 5;
  localparam int HOLD_CYCLES   = 600;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic             cal;
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] x;
  } pix_t;

  typedef enum logic [0:0] {
    STEP_PRESS = 1'b0,
    STEP_CFG   = 1'b1
  } step_kind_t;

  typedef struct packed {
    step_kind_t            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [PIX_W-1:0]      val;
    logic [4:0]            n_samp;
    logic [SAMPLE_W-1:0]   xs;
    logic [SAMPLE_W-1:0]   ys;
    logic                  typed;
    pix_t                  want;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;
  logic                  out_tuser;

  touch_average_calibrate_scale #(
    .SAMPLES_PER_AXIS(PER_AXIS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // press predictor state
  int                  press_pos;
  logic [12:0]         x_acc, y_acc;
  logic [PRESS_W-1:0]  presses_left;
  logic                first_press;
  logic [PIX_W-1:0]    scr_w, scr_h;
  logic [SAMPLE_W-1:0] x_lo, x_hi, y_lo, y_hi;

  pix_t  pending_pix[$];
  logic  use_typed;
  pix_t  typed_pix;

  int    mismatch_count = 0;
  int    cycle_count = 0;
  int    send_idle_pct = 0;
  int    rcv_stall_pct = 0;
  int    hold_left = 0;

  step_t steps [N_STEPS];

  function automatic logic [PIX_W-1:0] to_pixels(logic [SAMPLE_W-1:0] v,
                                                 logic [SAMPLE_W-1:0] lo,
                                                 logic [SAMPLE_W-1:0] hi,
                                                 logic [PIX_W-1:0] scale);
    logic [SAMPLE_W-1:0]      c;
    logic [PIX_W+SAMPLE_W-1:0] num;
    c = v;
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    if (hi <= lo) return '0;
    num = scale * (c - lo);
    return PIX_W'(num / (hi - lo));
  endfunction

  task automatic absorb_sample(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] xa, ya;
    pix_t p;
    if (press_pos < PER_AXIS) x_acc += s;
    else y_acc += s;
    press_pos++;
    if (press_pos < 2 * PER_AXIS) return;
    xa = SAMPLE_W'(x_acc / PER_AXIS);
    ya = SAMPLE_W'(y_acc / PER_AXIS);
    press_pos = 0;
    x_acc = '0;
    y_acc = '0;
    if (presses_left != 0) begin
      if (first_press) begin
        first_press = 1'b0;
        x_lo = xa;
        x_hi = xa;
        y_lo = ya;
        y_hi = ya;
      end else begin
        // each axis against its own bounds
        if (xa < x_lo) x_lo = xa;
        if (xa > x_hi) x_hi = xa;
        if (ya < y_lo) y_lo = ya;
        if (ya > y_hi) y_hi = ya;
      end
      presses_left--;
      p.x = '0;
      p.y = '0;
      p.cal = 1'b1;
    end else begin
      p.x = to_pixels(xa, x_lo, x_hi, scr_w);
      p.y = to_pixels(ya, y_lo, y_hi, scr_h);
      p.cal = 1'b0;
    end
    pending_pix.push_back(use_typed ? typed_pix : p);
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // called just after a falling edge, returns just after a falling edge
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= 16'(s);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_sample(s);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_pix.size() != 0);
  endtask

  task automatic wait_idle();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CAL_PRESSES: begin
        presses_left = val[PRESS_W-1:0];
        first_press  = 1'b1;
      end
      REG_SCREEN_W: scr_w = val;
      REG_SCREEN_H: scr_h = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_random_press();
    int style, xb, yb, v, noise, k;
    style = $urandom_range(0, 3);
    xb = $urandom_range(0, 1023);
    yb = $urandom_range(0, 1023);
    if (style == 2) begin
      xb = $urandom_range(0, 1) * 1023;
      yb = $urandom_range(0, 1) * 1023;
    end
    for (k = 0; k < 2 * PER_AXIS; k++) begin
      v = (k < PER_AXIS) ? xb : yb;
      noise = $urandom_range(0, 48);
      if (style == 3) v = $urandom_range(0, 1023);
      else if (style != 2) v = v + noise - 24;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      send_sample(v[SAMPLE_W-1:0]);
    end
  endtask

  function automatic logic [PIX_W-1:0] pick_scale();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 12'd1;
      2: return 12'd4095;
      default: return PIX_W'($urandom_range(1, 4095));
    endcase
  endfunction

  function automatic step_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] val);
    step_t t;
    t = '0;
    t.kind = STEP_CFG;
    t.idx  = idx;
    t.val  = val;
    return t;
  endfunction

  function automatic step_t press_row(int n, logic [SAMPLE_W-1:0] xs, logic [SAMPLE_W-1:0] ys);
    step_t t;
    t = '0;
    t.kind   = STEP_PRESS;
    t.n_samp = 5'(n);
    t.xs     = xs;
    t.ys     = ys;
    return t;
  endfunction

  function automatic step_t typed_row(int n, logic [SAMPLE_W-1:0] xs, logic [SAMPLE_W-1:0] ys,
                                      logic [PIX_W-1:0] wx, logic [PIX_W-1:0] wy, logic wc);
    step_t t;
    t = press_row(n, xs, ys);
    t.typed  = 1'b1;
    t.want.x = wx;
    t.want.y = wy;
    t.want.cal = wc;
    return t;
  endfunction

  // receiver: long hold-offs counted here, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin : watch_out
    pix_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pix.size() == 0) begin
        flag_mismatch("word with nothing pending", int'(out_tdata), 0);
      end else begin
        want = pending_pix.pop_front();
        if (out_tdata[PIX_W-1:0] != want.x)
          flag_mismatch("x_pixel", out_tdata[PIX_W-1:0], want.x);
        if (out_tdata[2*PIX_W-1:PIX_W] != want.y)
          flag_mismatch("y_pixel", out_tdata[2*PIX_W-1:PIX_W], want.y);
        if (out_tuser != want.cal)
          flag_mismatch("calibrating", out_tuser, want.cal);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int    r, k, ph, n;
    int    cal_set [N_PHASES];
    int    send_set [N_PHASES];
    int    rcv_set [N_PHASES];
    int    n_set [N_PHASES];
    step_t row;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    use_typed = 1'b0;
    typed_pix = '0;

    press_pos    = 0;
    x_acc        = '0;
    y_acc        = '0;
    presses_left = CAL_PRESSES_RST;
    first_press  = 1'b1;
    scr_w        = SCREEN_W_RST;
    scr_h        = SCREEN_H_RST;
    x_lo = '0; x_hi = '0; y_lo = '0; y_hi = '0;

    steps = '{
      // calibration cut to none in mid-press: bounds never set, so zero
      press_row(15, 10'd1023, 10'd1023),
      cfg_row(REG_CAL_PRESSES, 12'd0),
      typed_row(1, 10'd0, 10'd1023, 12'd0, 12'd0, 1'b0),
      cfg_row(REG_CAL_PRESSES, 12'd3),
      typed_row(16, 10'd0, 10'd0, 12'd0, 12'd0, 1'b1),
      typed_row(16, 10'd1023, 10'd1023, 12'd0, 12'd0, 1'b1),
      typed_row(16, 10'd512, 10'd300, 12'd0, 12'd0, 1'b1),
      // full span at the reset screen size
      typed_row(16, 10'd1023, 10'd1023, 12'd320, 12'd240, 1'b0),
      typed_row(16, 10'd0, 10'd0, 12'd0, 12'd0, 1'b0),
      press_row(16, 10'd511, 10'd700),
      cfg_row(REG_UNUSED, 12'hfff),
      cfg_row(REG_SCREEN_W, 12'd4095),
      cfg_row(REG_SCREEN_H, 12'd0),
      typed_row(16, 10'd1023, 10'd1023, 12'd4095, 12'd0, 1'b0),
      press_row(16, 10'd100, 10'd900),
      // single calibration press leaves a zero span on both axes
      cfg_row(REG_CAL_PRESSES, 12'd1),
      typed_row(16, 10'd600, 10'd600, 12'd0, 12'd0, 1'b1),
      typed_row(16, 10'd1023, 10'd0, 12'd0, 12'd0, 1'b0),
      cfg_row(REG_CAL_PRESSES, 12'd2),
      cfg_row(REG_SCREEN_H, 12'd1),
      typed_row(16, 10'd200, 10'd100, 12'd0, 12'd0, 1'b1),
      typed_row(16, 10'd800, 10'd900, 12'd0, 12'd0, 1'b1),
      // out of range on both sides, clamped to the bounds
      typed_row(16, 10'd1023, 10'd0, 12'd4095, 12'd0, 1'b0),
      typed_row(16, 10'd0, 10'd1023, 12'd0, 12'd1, 1'b0)
    };

    cal_set  = '{2, 0, 0, 0, 1};
    send_set = '{0, 49, 0, 20, 0};
    rcv_set  = '{0, 0, 49, 20, 0};
    n_set    = '{HOLD_PRESSES + 1, 2, 1, 1, 1};

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < N_STEPS; r++) begin
      row = steps[r];
      if (row.kind == STEP_CFG) begin
        wait_idle();
        write_reg(row.idx, row.val);
      end else begin
        use_typed = row.typed;
        typed_pix = row.want;
        for (k = 0; k < int'(row.n_samp); k++)
          send_sample(press_pos < PER_AXIS ? row.xs : row.ys);
        use_typed = 1'b0;
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      send_idle_pct = send_set[ph];
      rcv_stall_pct = rcv_set[ph];
      write_reg(REG_CAL_PRESSES, PIX_W'(cal_set[ph]));
      write_reg(REG_SCREEN_W, pick_scale());
      write_reg(REG_SCREEN_H, pick_scale());
      for (n = 0; n < n_set[ph]; n++) begin
        // stall the output long enough for the press queue to back up
        if (ph == 0 && n == 0) hold_left <= HOLD_CYCLES;
        if (ph == 0 && n == HOLD_PRESSES) drain_results();
        send_random_press();
      end
    end

    send_idle_pct = 0;
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
